/* src/apsp_pkg.sv */
// shared types, constants and microcode for the min-plus shortest path unit
package apsp_pkg;

    // fixed field widths
    localparam int unsigned DIST_W = 14;
    localparam int unsigned NODE_W = 6;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned PASS_W = 3;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // distance that stands for no edge
    localparam logic [DIST_W-1:0] INF_DIST = 14'd10000;

    // reset value of the matrix size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // register index of the matrix size register (paddr word bit)
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
        logic [DIST_W-1:0] weight;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_path;
        logic              run_done;
    } t_result;

    // microcode fields
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_K_MORE,
        C_J_MORE,
        C_I_MORE,
        C_PASS_ZERO,
        C_PASS_MORE
    } t_cond;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_cnt_op i_op;
        t_cnt_op j_op;
        t_cnt_op k_op;
        logic    best_init;
        logic    acc;
        logic    rd_mul;
        logic    wr_prod;
        logic    rd_prod;
        logic    wr_dist;
        logic    pass_ld;
        logic    pass_dec;
        logic    done;
        t_cond   cond;
        t_step   target;
    } t_ctrl;

    // loop status seen by the sequencer
    typedef struct packed {
        logic k_more;
        logic j_more;
        logic i_more;
        logic pass_zero;
        logic pass_more;
    } t_flags;

    // microcode step addresses
    localparam t_step ST_LOAD = 4'd0;
    localparam t_step ST_PASS = 4'd1;
    localparam t_step ST_ROWI = 4'd2;
    localparam t_step ST_CELL = 4'd3;
    localparam t_step ST_RD   = 4'd4;
    localparam t_step ST_ACC  = 4'd5;
    localparam t_step ST_WRP  = 4'd6;
    localparam t_step ST_NXI  = 4'd7;
    localparam t_step ST_CPI  = 4'd8;
    localparam t_step ST_CPJ  = 4'd9;
    localparam t_step ST_CPR  = 4'd10;
    localparam t_step ST_CPW  = 4'd11;
    localparam t_step ST_CPN  = 4'd12;
    localparam t_step ST_NXP  = 4'd13;
    localparam t_step ST_DONE = 4'd14;

    localparam t_ctrl CTRL_NOP = '{
        i_op: CNT_HOLD, j_op: CNT_HOLD, k_op: CNT_HOLD,
        best_init: 1'b0, acc: 1'b0, rd_mul: 1'b0, wr_prod: 1'b0,
        rd_prod: 1'b0, wr_dist: 1'b0, pass_ld: 1'b0, pass_dec: 1'b0,
        done: 1'b0, cond: C_NONE, target: ST_LOAD
    };

    // microcode rom: one control word per step
    function automatic t_ctrl ucode_rom(input t_step step);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (step)
            ST_LOAD: begin
                w.pass_ld = 1'b1;
                w.cond    = C_PASS_ZERO;
                w.target  = ST_DONE;
            end
            ST_PASS: w.i_op = CNT_CLR;
            ST_ROWI: w.j_op = CNT_CLR;
            ST_CELL: begin
                w.k_op      = CNT_CLR;
                w.best_init = 1'b1;
            end
            ST_RD:   w.rd_mul = 1'b1;
            ST_ACC: begin
                w.acc    = 1'b1;
                w.k_op   = CNT_INC;
                w.cond   = C_K_MORE;
                w.target = ST_RD;
            end
            ST_WRP: begin
                w.wr_prod = 1'b1;
                w.j_op    = CNT_INC;
                w.cond    = C_J_MORE;
                w.target  = ST_CELL;
            end
            ST_NXI: begin
                w.i_op   = CNT_INC;
                w.cond   = C_I_MORE;
                w.target = ST_ROWI;
            end
            ST_CPI:  w.i_op = CNT_CLR;
            ST_CPJ:  w.j_op = CNT_CLR;
            ST_CPR:  w.rd_prod = 1'b1;
            ST_CPW: begin
                w.wr_dist = 1'b1;
                w.j_op    = CNT_INC;
                w.cond    = C_J_MORE;
                w.target  = ST_CPR;
            end
            ST_CPN: begin
                w.i_op   = CNT_INC;
                w.cond   = C_I_MORE;
                w.target = ST_CPJ;
            end
            ST_NXP: begin
                w.pass_dec = 1'b1;
                w.cond     = C_PASS_MORE;
                w.target   = ST_PASS;
            end
            ST_DONE: w.done = 1'b1;
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

    // number of squarings: ceil(log2 n)
    function automatic logic [PASS_W-1:0] pass_count(input logic [SIZE_W-1:0] n);
        logic [PASS_W-1:0] cnt;
        cnt = '0;
        for (int p = 0; p < SIZE_W; p++) begin
            if ((SIZE_W'(1) << p) < n) begin
                cnt = PASS_W'(p + 1);
            end
        end
        return cnt;
    endfunction

endpackage

/* src/apsp_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
module apsp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  apsp_pkg::t_flags i_flags,
    output apsp_pkg::t_ctrl o_ctrl,
    output logic            o_run
);

    logic            r_run;
    apsp_pkg::t_step r_step;
    apsp_pkg::t_step n_step;
    apsp_pkg::t_ctrl w_word;
    logic            w_take;

    // control word of the current step
    assign w_word = apsp_pkg::ucode_rom(r_step);

    // jump condition
    always_comb begin
        unique case (w_word.cond)
            apsp_pkg::C_NONE:      w_take = 1'b0;
            apsp_pkg::C_K_MORE:    w_take = i_flags.k_more;
            apsp_pkg::C_J_MORE:    w_take = i_flags.j_more;
            apsp_pkg::C_I_MORE:    w_take = i_flags.i_more;
            apsp_pkg::C_PASS_ZERO: w_take = i_flags.pass_zero;
            apsp_pkg::C_PASS_MORE: w_take = i_flags.pass_more;
            default:               w_take = 1'b0;
        endcase
        n_step = w_take ? w_word.target : r_step + apsp_pkg::t_step'(1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= apsp_pkg::ST_LOAD;
        end else if (!r_run) begin
            if (i_go) begin
                r_run  <= 1'b1;
                r_step <= apsp_pkg::ST_LOAD;
            end
        end else begin
            r_step <= n_step;
            if (w_word.done) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_ctrl = r_run ? w_word : apsp_pkg::CTRL_NOP;
    assign o_run  = r_run;

endmodule

/* src/all_pairs_shortest_path_minplus_unit.sv */
// all-pairs shortest path unit: min-plus repeated squaring of a stored distance matrix
//
// Write and read items are taken one per cycle (busy stays low); a read answers on
// o_result with o_result_stb through the read port register and the result register,
// a write answers nothing. A run item holds busy high while the microcode runs and
// strobes run_done in the first cycle in which busy is low again; the microcode inner
// loop takes two steps per (i, j, k) term through the two read ports of the distance
// memory, and each squaring adds a copy sweep of the product memory. Results are strobed
// for one cycle and must be taken as they come. Entries must be written before they
// are read or used by a run; the memories have no reset and need no clearing pass.
module all_pairs_shortest_path_minplus_unit #(
    parameter int unsigned MAX_NODES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  apsp_pkg::t_item               i_item,
    // result channel
    output logic                          o_result_stb,
    output apsp_pkg::t_result             o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apsp_pkg::APB_AW-1:0]   paddr,
    input  logic [apsp_pkg::APB_DW-1:0]   pwdata,
    output logic [apsp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned IDX_W = $clog2(MAX_NODES);
    localparam int unsigned ADDR_W = 2 * IDX_W;
    localparam int unsigned DEPTH = 2 ** ADDR_W;

    logic [apsp_pkg::SIZE_W-1:0] r_size;
    logic [apsp_pkg::SIZE_W-1:0] w_n;
    logic [IDX_W-1:0]            w_last;
    logic [apsp_pkg::PASS_W-1:0] w_passes;

    logic                        w_accept;
    logic                        w_in_range;
    logic                        w_run_go;
    logic                        w_rd_go;
    logic                        w_wr_go;
    logic [apsp_pkg::DIST_W-1:0] w_wr_weight;

    apsp_pkg::t_ctrl             w_ctrl;
    apsp_pkg::t_flags            w_flags;
    logic                        w_run;

    logic [IDX_W-1:0]            r_i;
    logic [IDX_W-1:0]            r_j;
    logic [IDX_W-1:0]            r_k;
    logic [apsp_pkg::PASS_W-1:0] r_pass;
    logic [apsp_pkg::DIST_W-1:0] r_best;

    logic [apsp_pkg::DIST_W-1:0] r_dist_mem [DEPTH];
    logic [apsp_pkg::DIST_W-1:0] r_prod_mem [DEPTH];
    logic [apsp_pkg::DIST_W-1:0] r_qa;
    logic [apsp_pkg::DIST_W-1:0] r_qb;
    logic [apsp_pkg::DIST_W-1:0] r_pq;
    logic [ADDR_W-1:0]           w_addr_a;
    logic [ADDR_W-1:0]           w_addr_b;
    logic [ADDR_W-1:0]           w_addr_ij;
    logic [ADDR_W-1:0]           w_addr_item;
    logic                        w_rd_a;

    logic [apsp_pkg::DIST_W:0]   w_sum;

    logic                        r_rd_vld;
    logic                        r_rd_oor;
    logic                        r_stb;
    apsp_pkg::t_result           r_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= apsp_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite
                     && paddr[2] == apsp_pkg::REG_MATRIX_SIZE) begin
            r_size <= pwdata[apsp_pkg::SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == apsp_pkg::REG_MATRIX_SIZE)
                  ? apsp_pkg::APB_DW'(r_size) : '0;

    // effective node count, last index and squaring count
    always_comb begin
        if (r_size == '0) begin
            w_n = apsp_pkg::SIZE_W'(1);
        end else if (32'(r_size) > MAX_NODES) begin
            w_n = apsp_pkg::SIZE_W'(MAX_NODES);
        end else begin
            w_n = r_size;
        end
        w_last   = IDX_W'(w_n - apsp_pkg::SIZE_W'(1));
        w_passes = apsp_pkg::pass_count(w_n);
    end

    // item decode
    assign w_accept   = start && !busy;
    assign w_in_range = (apsp_pkg::SIZE_W'(i_item.row) < w_n)
                     && (apsp_pkg::SIZE_W'(i_item.col) < w_n);
    assign w_run_go   = w_accept && (i_item.op == apsp_pkg::OP_RUN);
    assign w_rd_go    = w_accept && (i_item.op == apsp_pkg::OP_READ);
    assign w_wr_go    = w_accept && (i_item.op == apsp_pkg::OP_WRITE) && w_in_range;

    // no edge off the diagonal and oversize weights become INF
    always_comb begin
        if (i_item.weight >= apsp_pkg::INF_DIST
            || (i_item.row != i_item.col && i_item.weight == '0)) begin
            w_wr_weight = apsp_pkg::INF_DIST;
        end else begin
            w_wr_weight = i_item.weight;
        end
    end

    // sequencer
    assign w_flags.k_more    = (r_k != w_last);
    assign w_flags.j_more    = (r_j != w_last);
    assign w_flags.i_more    = (r_i != w_last);
    assign w_flags.pass_zero = (w_passes == '0);
    assign w_flags.pass_more = (r_pass != apsp_pkg::PASS_W'(1));

    apsp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_run_go),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_run   (w_run)
    );

    assign busy = w_run;

    // loop counters
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.i_op)
            apsp_pkg::CNT_CLR: r_i <= '0;
            apsp_pkg::CNT_INC: r_i <= r_i + IDX_W'(1);
            default:           r_i <= r_i;
        endcase
        unique case (w_ctrl.j_op)
            apsp_pkg::CNT_CLR: r_j <= '0;
            apsp_pkg::CNT_INC: r_j <= r_j + IDX_W'(1);
            default:           r_j <= r_j;
        endcase
        unique case (w_ctrl.k_op)
            apsp_pkg::CNT_CLR: r_k <= '0;
            apsp_pkg::CNT_INC: r_k <= r_k + IDX_W'(1);
            default:           r_k <= r_k;
        endcase
        if (w_ctrl.pass_ld) begin
            r_pass <= w_passes;
        end else if (w_ctrl.pass_dec) begin
            r_pass <= r_pass - apsp_pkg::PASS_W'(1);
        end
    end

    // min-plus accumulate, INF operands skipped
    assign w_sum = {1'b0, r_qa} + {1'b0, r_qb};

    always_ff @(posedge i_clk) begin
        if (w_ctrl.best_init) begin
            r_best <= apsp_pkg::INF_DIST;
        end else if (w_ctrl.acc && r_qa != apsp_pkg::INF_DIST
                     && r_qb != apsp_pkg::INF_DIST
                     && w_sum < {1'b0, r_best}) begin
            r_best <= w_sum[apsp_pkg::DIST_W-1:0];
        end
    end

    // memory addresses
    assign w_addr_item = {IDX_W'(i_item.row), IDX_W'(i_item.col)};
    assign w_addr_ij   = {r_i, r_j};
    assign w_addr_a    = w_ctrl.rd_mul ? {r_i, r_k} : w_addr_item;
    assign w_addr_b    = {r_k, r_j};
    assign w_rd_a      = w_ctrl.rd_mul || w_rd_go;

    // distance memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_wr_go) begin
            r_dist_mem[w_addr_item] <= w_wr_weight;
        end else if (w_ctrl.wr_dist) begin
            r_dist_mem[w_addr_ij] <= r_pq;
        end
        if (w_rd_a) begin
            r_qa <= r_dist_mem[w_addr_a];
        end
        if (w_ctrl.rd_mul) begin
            r_qb <= r_dist_mem[w_addr_b];
        end
    end

    // product memory: scratch for one squaring
    always_ff @(posedge i_clk) begin
        if (w_ctrl.wr_prod) begin
            r_prod_mem[w_addr_ij] <= r_best;
        end
        if (w_ctrl.rd_prod) begin
            r_pq <= r_prod_mem[w_addr_ij];
        end
    end

    // read transaction in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_go;
        end
        r_rd_oor <= !w_in_range;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= r_rd_vld || w_ctrl.done;
        end
        if (w_ctrl.done) begin
            r_res <= '{distance: '0, no_path: 1'b0, run_done: 1'b1};
        end else if (r_rd_oor || r_qa >= apsp_pkg::INF_DIST) begin
            r_res <= '{distance: '0, no_path: 1'b1, run_done: 1'b0};
        end else begin
            r_res <= '{distance: r_qa, no_path: 1'b0, run_done: 1'b0};
        end
    end

    assign o_result_stb = r_stb;
    assign o_result     = r_res;

    // a run result follows a busy period
    a_run_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb && o_result.run_done |-> $past(busy))
        else $error("run_done strobed without a run in progress");

    // run results carry no distance and no no-path flag
    a_run_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb && o_result.run_done |-> o_result.distance == '0 && !o_result.no_path)
        else $error("run result carries read fields");

    // a no-path answer reports zero distance
    a_no_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb && o_result.no_path |-> o_result.distance == '0)
        else $error("no-path result with nonzero distance");

    // a read result is strobed once a taken read passes the read register and the result register
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == apsp_pkg::OP_READ |=> ##1 o_result_stb)
        else $error("read result missing");

endmodule

/* dv/tb_all_pairs_shortest_path_minplus_unit.sv */
// testbench for the min-plus all-pairs shortest path unit: directed table, random traffic, checks
`timescale 1ns / 100ps

module tb_all_pairs_shortest_path_minplus_unit;

    localparam int NODES_MAX = 64;
    // squaring runs stay at or below this size
    localparam int RUN_NODES_MAX = 16;
    localparam int ITEM_TARGET = 1350;
    // cycles without any transaction before the run is given up
    localparam int STALL_LIMIT = 150000;
    // a write answers nothing, a read answers through the read and result registers after it is taken
    localparam int SETTLE_CYCLES = 6;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic {
        ROW_ITEM,
        ROW_SIZE
    } t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind                   kind;
        apsp_pkg::t_item             item;
        logic [apsp_pkg::SIZE_W-1:0] size_val;
        logic                        pinned;
        apsp_pkg::t_result           want;
    } t_script_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    apsp_pkg::t_item             i_item;
    logic                        o_result_stb;
    apsp_pkg::t_result           o_result;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [apsp_pkg::APB_AW-1:0] paddr;
    logic [apsp_pkg::APB_DW-1:0] pwdata;
    logic [apsp_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    all_pairs_shortest_path_minplus_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_result_stb (o_result_stb),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow of the matrix, the scratch product and the size register
    logic [apsp_pkg::DIST_W-1:0] dist_mat [NODES_MAX*NODES_MAX];
    logic [apsp_pkg::DIST_W-1:0] prod_mat [NODES_MAX*NODES_MAX];
    logic [apsp_pkg::SIZE_W-1:0] size_reg;
    apsp_pkg::t_result           pending_answers [$];

    // generator bookkeeping: which entries hold a written value
    bit                loaded [NODES_MAX*NODES_MAX];
    int                gen_nodes;
    logic              pin_valid;
    apsp_pkg::t_result pin_answer;
    t_script_row       script [$];

    int burst_left;
    int items_sent;
    int reads_sent;
    int runs_sent;
    int size_writes;
    int largest_run;
    int mismatches;
    int stall_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int live_nodes(input logic [apsp_pkg::SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > NODES_MAX) return NODES_MAX;
        return int'(s);
    endfunction

    function automatic apsp_pkg::t_item make_item(input logic [1:0] op, input int r, c, w);
        apsp_pkg::t_item it;
        it.op     = op;
        it.row    = apsp_pkg::NODE_W'(r);
        it.col    = apsp_pkg::NODE_W'(c);
        it.weight = apsp_pkg::DIST_W'(w);
        return it;
    endfunction

    function automatic apsp_pkg::t_result make_reply(input int d, input logic np,
                                                     input logic done);
        apsp_pkg::t_result res;
        res.distance = apsp_pkg::DIST_W'(d);
        res.no_path  = np;
        res.run_done = done;
        return res;
    endfunction

    function automatic t_script_row item_row(input logic [1:0] op, input int r, c, w);
        t_script_row s;
        s      = '0;
        s.kind = ROW_ITEM;
        s.item = make_item(op, r, c, w);
        return s;
    endfunction

    function automatic t_script_row pinned_row(input logic [1:0] op, input int r, c, w,
                                               input apsp_pkg::t_result want);
        t_script_row s;
        s        = item_row(op, r, c, w);
        s.pinned = 1'b1;
        s.want   = want;
        return s;
    endfunction

    function automatic t_script_row size_row(input logic [apsp_pkg::SIZE_W-1:0] v);
        t_script_row s;
        s          = '0;
        s.kind     = ROW_SIZE;
        s.size_val = v;
        return s;
    endfunction

    // weights lean toward no-edge and short hops, with some at or above the no-edge value
    function automatic logic [apsp_pkg::DIST_W-1:0] draw_weight();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4, 5: return apsp_pkg::DIST_W'($urandom_range(1, 40));
            6, 7:    return apsp_pkg::DIST_W'($urandom_range(1, 9999));
            8:       return apsp_pkg::DIST_W'($urandom_range(10000, 16383));
            default: return apsp_pkg::DIST_W'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // one min-plus squaring of the live n-by-n corner
    task automatic square_matrix(input int n);
        int best;
        int a;
        int b;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                best = int'(apsp_pkg::INF_DIST);
                for (int k = 0; k < n; k++) begin
                    a = dist_mat[i*NODES_MAX+k];
                    b = dist_mat[k*NODES_MAX+j];
                    // no-edge operands are skipped, sums at or above no-edge never win
                    if (a != apsp_pkg::INF_DIST && b != apsp_pkg::INF_DIST && a + b < best)
                        best = a + b;
                end
                prod_mat[i*NODES_MAX+j] = apsp_pkg::DIST_W'(best);
            end
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                dist_mat[i*NODES_MAX+j] = prod_mat[i*NODES_MAX+j];
    endtask

    // predictor: update the shadow state and work out the answer of one transaction
    task automatic apply_item(input apsp_pkg::t_item it, output bit has,
                              output apsp_pkg::t_result res);
        int n;
        int w;
        int v;
        int passes;
        n      = live_nodes(size_reg);
        has    = 1'b0;
        res    = '0;
        passes = 0;
        case (it.op)
            apsp_pkg::OP_WRITE: begin
                if (it.row < n && it.col < n) begin
                    w = it.weight;
                    if (w >= apsp_pkg::INF_DIST || (it.row != it.col && w == 0))
                        w = int'(apsp_pkg::INF_DIST);
                    dist_mat[it.row*NODES_MAX+it.col] = apsp_pkg::DIST_W'(w);
                end
            end
            apsp_pkg::OP_RUN: begin
                while ((1 << passes) < n) passes++;
                repeat (passes) square_matrix(n);
                has          = 1'b1;
                res.run_done = 1'b1;
            end
            apsp_pkg::OP_READ: begin
                has = 1'b1;
                if (it.row >= n || it.col >= n) begin
                    res.no_path = 1'b1;
                end else begin
                    v = dist_mat[it.row*NODES_MAX+it.col];
                    if (v >= apsp_pkg::INF_DIST) res.no_path = 1'b1;
                    else res.distance = apsp_pkg::DIST_W'(v);
                end
            end
            default: ;
        endcase
    endtask

    // result check first, then the transaction taken at the same edge
    always @(posedge i_clk) begin
        bit                has;
        apsp_pkg::t_result want;
        if (i_rst_n) begin
            if (o_result_stb) begin
                if (pending_answers.size() == 0) begin
                    note_mismatch("unexpected result, distance", o_result.distance, 0);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_result.distance !== want.distance)
                        note_mismatch("distance", o_result.distance, want.distance);
                    if (o_result.no_path !== want.no_path)
                        note_mismatch("no_path", o_result.no_path, want.no_path);
                    if (o_result.run_done !== want.run_done)
                        note_mismatch("run_done", o_result.run_done, want.run_done);
                end
            end
            if (start && !busy) begin
                apply_item(i_item, has, want);
                if (has) pending_answers.push_back(pin_valid ? pin_answer : want);
            end
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_stb || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one transaction after a random gap and wait until it is taken
    task automatic send_item(input apsp_pkg::t_item it, input logic pinned,
                             input apsp_pkg::t_result want);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(8, 48);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_item     <= it;
        pin_valid  <= pinned;
        pin_answer <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (it.op)
            apsp_pkg::OP_WRITE: begin
                if (it.row < gen_nodes && it.col < gen_nodes)
                    loaded[it.row*NODES_MAX+it.col] = 1'b1;
            end
            apsp_pkg::OP_RUN: begin
                runs_sent++;
                if (gen_nodes > largest_run) largest_run = gen_nodes;
            end
            apsp_pkg::OP_READ: reads_sent++;
            default: ;
        endcase
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    task automatic send_plain(input logic [1:0] op, input int r, c, w);
        send_item(make_item(op, r, c, w), 1'b0, '0);
    endtask

    // drain every expected answer and let a trailing write finish
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write matrix_size over the config port, then read it back
    task automatic set_size(input logic [apsp_pkg::SIZE_W-1:0] v);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {apsp_pkg::REG_MATRIX_SIZE, 2'b00};
        pwdata  <= apsp_pkg::APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        size_reg  = v;
        gen_nodes = live_nodes(v);
        size_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== apsp_pkg::APB_DW'(v))
            note_mismatch("matrix_size readback", int'(prdata), int'(v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        t_script_row                 row;
        logic [apsp_pkg::SIZE_W-1:0] sz;
        int                          n;
        int                          r;
        int                          c;
        int                          pick;
        int                          ops;

        // every input known from time zero, reset held
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        pin_valid  <= 1'b0;
        pin_answer <= '0;
        size_reg   = apsp_pkg::SIZE_RESET;
        gen_nodes  = live_nodes(apsp_pkg::SIZE_RESET);
        burst_left = 0;

        // directed table: extremes at reset size, a two-node run, size clamping
        script.push_back(item_row(apsp_pkg::OP_WRITE, 0, 0, 0));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 63, 63, 9999));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 63, 63, 0,
                                    make_reply(9999, 1'b0, 1'b0)));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 0, 63, 0));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 0, 63, 0, make_reply(0, 1'b1, 1'b0)));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 63, 0, 16383));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 63, 0, 16383,
                                    make_reply(0, 1'b1, 1'b0)));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 1, 2, 10000));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 1, 2, 0, make_reply(0, 1'b1, 1'b0)));
        script.push_back(item_row(OP_UNUSED, 63, 63, 16383));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 0, 0, 0, make_reply(0, 1'b0, 1'b0)));
        script.push_back(size_row(7'd2));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 0, 1, 5));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 1, 0, 0));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 1, 1, 7));
        script.push_back(pinned_row(apsp_pkg::OP_RUN, 63, 63, 16383,
                                    make_reply(0, 1'b0, 1'b1)));
        script.push_back(item_row(apsp_pkg::OP_READ, 0, 1, 0));
        script.push_back(item_row(apsp_pkg::OP_READ, 1, 1, 0));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 1, 0, 0, make_reply(0, 1'b1, 1'b0)));
        script.push_back(item_row(apsp_pkg::OP_WRITE, 2, 2, 1));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 2, 0, 0, make_reply(0, 1'b1, 1'b0)));
        script.push_back(size_row(7'd0));
        script.push_back(pinned_row(apsp_pkg::OP_RUN, 0, 0, 0, make_reply(0, 1'b0, 1'b1)));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 0, 1, 0, make_reply(0, 1'b1, 1'b0)));
        script.push_back(size_row(7'd1));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 0, 0, 0, make_reply(0, 1'b0, 1'b0)));
        script.push_back(size_row(7'd127));
        script.push_back(pinned_row(apsp_pkg::OP_READ, 63, 63, 0,
                                    make_reply(9999, 1'b0, 1'b0)));
        script.push_back(item_row(apsp_pkg::OP_READ, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (script[idx]) begin
            row = script[idx];
            if (row.kind == ROW_SIZE) set_size(row.size_val);
            else send_item(row.item, row.pinned, row.want);
        end

        // random episodes: pick a size, load and square when small enough, then mixed traffic
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0:       sz = 7'd0;
                1:       sz = 7'd1;
                2:       sz = 7'd64;
                3:       sz = 7'd127;
                4:       sz = apsp_pkg::SIZE_W'($urandom_range(65, 126));
                5, 6:    sz = apsp_pkg::SIZE_W'($urandom_range(7, 12));
                7:       sz = apsp_pkg::SIZE_W'(RUN_NODES_MAX);
                default: sz = apsp_pkg::SIZE_W'($urandom_range(2, 6));
            endcase
            set_size(sz);
            n = gen_nodes;

            // well-formed sequence: fill the live matrix, then square it
            if (n <= RUN_NODES_MAX) begin
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        send_plain(apsp_pkg::OP_WRITE, i, j, draw_weight());
                send_plain(apsp_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 16383));
            end

            ops = $urandom_range(10, 40);
            repeat (ops) begin
                r    = $urandom_range(0, n - 1);
                c    = $urandom_range(0, n - 1);
                pick = $urandom_range(0, 9);
                // out-of-range indexes exist only below the full size
                if ((pick == 4 || pick == 7) && n == NODES_MAX) pick = pick - 4;
                if (pick == 4 || pick == 7) begin
                    if ($urandom_range(0, 1)) r = $urandom_range(n, 63);
                    else c = $urandom_range(n, 63);
                end
                // never read an entry that was not written; write it instead
                if (pick <= 3 && !loaded[r*NODES_MAX+c]) pick = 5;
                if (pick == 9 && n > RUN_NODES_MAX) pick = 5;
                case (pick)
                    0, 1, 2, 3, 4:
                        send_plain(apsp_pkg::OP_READ, r, c, $urandom_range(0, 16383));
                    5, 6, 7:
                        send_plain(apsp_pkg::OP_WRITE, r, c, draw_weight());
                    8: send_plain(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 16383));
                    default: send_plain(apsp_pkg::OP_RUN, r, c, $urandom_range(0, 16383));
                endcase
            end
        end

        settle();
        $display("covered %0d transactions: %0d reads, %0d squaring runs up to %0d nodes",
                 items_sent, reads_sent, runs_sent, largest_run);
        $display("matrix_size written %0d times, %0d field mismatches", size_writes, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
